FILE: hw/rtl/kga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kga_pkg
// Shared types and constants for the kerned glyph advance block.
// ----------------------------------------------------------------------------
package kga_pkg;

	// default table sizes
	localparam int GLYPH_SLOTS_DEF  = 256;
	localparam int KERN_ENTRIES_DEF = 256;

	// request codes
	typedef enum logic [1:0] {
		REQ_QUERY    = 2'd0,
		REQ_GLYPH_WR = 2'd1,
		REQ_KERN_WR  = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERN_COUNT = 1'b1;
	localparam logic [9:0] SPACING_RST = 10'd100;

	// first printable code, maps to glyph slot 0; codes above 0x7f continue
	// at slot 96, which is the same code - 0x20 mapping
	localparam logic [15:0] CODE_BASE = 16'h0020;

	// divide by 100: floor(p * ceil(2^27/100) / 2^27) is exact for p < 2^19
	localparam int          PROD1_W     = 19;
	localparam int          PROD2_W     = 40;
	localparam int          RECIP_SHIFT = 27;
	localparam logic [20:0] RECIP_MUL   = 21'd1342178;

	typedef struct packed {
		logic              valid;
		logic [7:0]        advance;
		logic signed [7:0] offset;
		logic              has_kern;
	} glyph_entry_t;

	typedef struct packed {
		logic [31:0]       key;
		logic signed [7:0] amount;
	} kern_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic glyph_wr;
		logic kern_wr;
		logic glyph_rd;
		logic rd_prev;
		logic cap_cur;
		logic search_init;
		logic probe;
		logic cmp;
		logic mul;
		logic div;
		logic finish;
		logic finish_zero;
	} kga_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic clear_last;
		logic kern_en;
		logic range_open;
		logic hit;
	} kga_stat_t;

endpackage

FILE: hw/rtl/kga_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kga_ctrl
// Sequencer: table clear after reset, request decode, glyph reads, kern
// binary search and the two-step scaling.
// ----------------------------------------------------------------------------
module kga_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kga_pkg::kga_stat_t stat,
	output kga_pkg::kga_cmd_t  cmd
);
	import kga_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_RD_PREV,
		ST_INIT,
		ST_PROBE,
		ST_CMP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.req)
					REQ_QUERY: begin
						cmd.glyph_rd = 1'b1;
						state_d      = ST_RD_PREV;
					end
					REQ_GLYPH_WR: begin
						cmd.glyph_wr    = 1'b1;
						cmd.finish_zero = 1'b1;
						state_d         = ST_IDLE;
					end
					REQ_KERN_WR: begin
						cmd.kern_wr     = 1'b1;
						cmd.finish_zero = 1'b1;
						state_d         = ST_IDLE;
					end
					default: begin
						cmd.finish_zero = 1'b1;
						state_d         = ST_IDLE;
					end
				endcase
			end
			ST_RD_PREV: begin
				cmd.cap_cur  = 1'b1;
				cmd.glyph_rd = 1'b1;
				cmd.rd_prev  = 1'b1;
				state_d      = ST_INIT;
			end
			ST_INIT: begin
				cmd.search_init = 1'b1;
				state_d         = ST_PROBE;
			end
			ST_PROBE: begin
				if (stat.kern_en && stat.range_open) begin
					cmd.probe = 1'b1;
					state_d   = ST_CMP;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = stat.hit ? ST_MUL : ST_PROBE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

FILE: hw/rtl/kga_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kga_datapath
// Glyph and kern tables, config registers, search bounds, sum and scaling.
// ----------------------------------------------------------------------------
module kga_datapath #(
	parameter int GLYPH_SLOTS  = kga_pkg::GLYPH_SLOTS_DEF,
	parameter int KERN_ENTRIES = kga_pkg::KERN_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kga_pkg::kga_cmd_t                cmd,
	output kga_pkg::kga_stat_t               stat,
	input  logic                             cfg_wr_en,
	input  logic [kga_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kga_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [1:0]                       req_type,
	input  logic [15:0]                      char_code,
	input  logic [15:0]                      prev_code,
	input  logic [7:0]                       glyph_advance,
	input  logic signed [7:0]                glyph_offset,
	input  logic                             glyph_has_kern,
	input  logic [7:0]                       kern_slot,
	input  logic signed [7:0]                kern_amount,
	output logic                             done,
	output logic [12:0]                      width,
	output logic                             unknown_char,
	output logic                             kern_applied
);
	import kga_pkg::*;

	localparam int GW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int KW = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
	localparam int CW = $clog2(KERN_ENTRIES + 1);
	localparam logic [GW-1:0] CLR_LAST = GW'(GLYPH_SLOTS - 1);

	// config registers
	logic [9:0] spacing_q;
	logic [8:0] kern_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q    <= SPACING_RST;
			kern_count_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SPACING:    spacing_q    <= cfg_data;
				CFG_KERN_COUNT: kern_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic [1:0]        req_q;
	logic [15:0]       cur_q, prev_q;
	logic [7:0]        adv_in_q, kslot_q;
	logic signed [7:0] off_in_q, kamt_q;
	logic              hk_in_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			cur_q    <= char_code;
			prev_q   <= prev_code;
			adv_in_q <= glyph_advance;
			off_in_q <= glyph_offset;
			hk_in_q  <= glyph_has_kern;
			kslot_q  <= kern_slot;
			kamt_q   <= kern_amount;
		end
	end

	// code to slot
	logic [31:0]   cur_off32, prev_off32, kslot32;
	logic          cur_ok, prev_ok, kslot_ok;
	logic [GW-1:0] cur_slot, prev_slot;

	assign cur_off32  = 32'(cur_q) - 32'(CODE_BASE);
	assign prev_off32 = 32'(prev_q) - 32'(CODE_BASE);
	assign cur_ok     = (cur_q >= CODE_BASE) && (cur_off32 < 32'(GLYPH_SLOTS));
	assign prev_ok    = (prev_q >= CODE_BASE) && (prev_off32 < 32'(GLYPH_SLOTS));
	assign cur_slot   = cur_off32[GW-1:0];
	assign prev_slot  = prev_off32[GW-1:0];
	assign kslot32    = 32'(kslot_q);
	assign kslot_ok   = kslot32 < 32'(KERN_ENTRIES);

	// glyph table
	glyph_entry_t  glyph_mem [GLYPH_SLOTS];
	glyph_entry_t  glyph_rd_q, g_wdata;
	logic          g_we;
	logic [GW-1:0] g_waddr, g_raddr, clr_idx_q;

	always_comb begin
		g_we    = 1'b0;
		g_waddr = cur_slot;
		g_wdata = '{valid: 1'b1, advance: adv_in_q, offset: off_in_q, has_kern: hk_in_q};
		if (cmd.clear) begin
			g_we    = 1'b1;
			g_waddr = clr_idx_q;
			g_wdata = '0;
		end else if (cmd.glyph_wr && cur_ok) begin
			g_we = 1'b1;
		end
	end

	assign g_raddr = cmd.rd_prev ? prev_slot : cur_slot;

	always_ff @(posedge clk) begin
		if (g_we) glyph_mem[g_waddr] <= g_wdata;
		if (cmd.glyph_rd) glyph_rd_q <= glyph_mem[g_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_idx_q <= '0;
		else if (cmd.clear) clr_idx_q <= clr_idx_q + 1'b1;
	end

	// kern table and search bounds
	kern_entry_t   kern_mem [KERN_ENTRIES];
	kern_entry_t   kern_rd_q;
	logic [CW-1:0] lo_q, hi_q, mid, hi_init;
	logic [CW:0]   mid_sum;
	logic [31:0]   kc32, key;
	logic          hit;

	assign key     = {prev_q, cur_q};
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign kc32    = 32'(kern_count_q);
	assign hi_init = (kc32 > 32'(KERN_ENTRIES)) ? CW'(KERN_ENTRIES) : kc32[CW-1:0];
	assign hit     = (kern_rd_q.key == key);

	always_ff @(posedge clk) begin
		if (cmd.kern_wr && kslot_ok)
			kern_mem[kslot32[KW-1:0]] <= '{key: key, amount: kamt_q};
		if (cmd.probe) kern_rd_q <= kern_mem[mid[KW-1:0]];
	end

	logic              kern_en_q, applied_q, known_q;
	logic signed [7:0] amt_q, off_q;
	logic [7:0]        adv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q      <= '0;
			hi_q      <= '0;
			kern_en_q <= 1'b0;
			applied_q <= 1'b0;
		end else if (cmd.search_init) begin
			lo_q      <= '0;
			hi_q      <= hi_init;
			kern_en_q <= prev_ok && glyph_rd_q.valid && glyph_rd_q.has_kern;
			applied_q <= 1'b0;
		end else if (cmd.cmp) begin
			if (hit) applied_q <= 1'b1;
			else if (key < kern_rd_q.key) hi_q <= mid;
			else lo_q <= mid + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && hit) amt_q <= kern_rd_q.amount;
		if (cmd.cap_cur) begin
			known_q <= cur_ok && glyph_rd_q.valid;
			adv_q   <= glyph_rd_q.advance;
			off_q   <= glyph_rd_q.offset;
		end
	end

	// sum, clamp and scale
	logic signed [9:0]    base, kadd, sum;
	logic [8:0]           sum_clamp;
	logic [PROD1_W-1:0]   prod1_q;
	logic [PROD2_W-1:0]   prod2_q;

	assign base      = known_q ? ($signed({2'b00, adv_q}) + $signed({{2{off_q[7]}}, off_q}))
	                           : '0;
	assign kadd      = applied_q ? $signed({{2{amt_q[7]}}, amt_q}) : '0;
	assign sum       = base + kadd;
	assign sum_clamp = sum[9] ? '0 : sum[8:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) prod1_q <= PROD1_W'(sum_clamp) * PROD1_W'(spacing_q);
		if (cmd.div) prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(RECIP_MUL);
	end

	// result beat; 509 * 1023 / 100 stays below 8191, so the quotient fits
	logic        done_q, unk_q, kapp_q;
	logic [12:0] width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.finish || cmd.finish_zero;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			width_q <= prod2_q[PROD2_W-1:RECIP_SHIFT];
			unk_q   <= !known_q;
			kapp_q  <= applied_q;
		end else if (cmd.finish_zero) begin
			width_q <= '0;
			unk_q   <= 1'b0;
			kapp_q  <= 1'b0;
		end
	end

	assign done         = done_q;
	assign width        = width_q;
	assign unknown_char = unk_q;
	assign kern_applied = kapp_q;

	assign stat.req        = req_t'(req_q);
	assign stat.clear_last = (clr_idx_q == CLR_LAST);
	assign stat.kern_en    = kern_en_q;
	assign stat.range_open = (lo_q < hi_q);
	assign stat.hit        = hit;

endmodule

FILE: hw/rtl/kerned_glyph_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kerned_glyph_advance
// Horizontal advance of one character from a glyph table plus an optional
// kerning pair found by binary search in a sorted kern table.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  request   start, busy               req_type, char_code, prev_code,
//            (beat: start & !busy)     glyph_advance, glyph_offset,
//                                      glyph_has_kern, kern_slot, kern_amount
//  result    done (one-cycle strobe)   width, unknown_char, kern_applied
//  config    cfg_wr_en                 cfg_index, cfg_data
//
//  writes: a glyph or kern write also ends with a result beat
//  search: each kern probe is one kern table read and one compare; the
//    number of probes is 0 when the previous glyph starts no pairs, and at
//    most ceil(log2(n+1)) with n the kern_count capped at KERN_ENTRIES
//  reset: after arst_n releases, the glyph table is cleared one slot a cycle,
//    and busy stays high until the clear sweep is done
//  stalls: the receiver cannot stall; one item is in flight at a time
//
module kerned_glyph_advance #(
	parameter int GLYPH_SLOTS  = kga_pkg::GLYPH_SLOTS_DEF,
	parameter int KERN_ENTRIES = kga_pkg::KERN_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [15:0]                    char_code,
	input  logic [15:0]                    prev_code,
	input  logic [7:0]                     glyph_advance,
	input  logic signed [7:0]              glyph_offset,
	input  logic                           glyph_has_kern,
	input  logic [7:0]                     kern_slot,
	input  logic signed [7:0]              kern_amount,
	// result
	output logic                           done,
	output logic [12:0]                    width,
	output logic                           unknown_char,
	output logic                           kern_applied,
	// config
	input  logic                           cfg_wr_en,
	input  logic [kga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kga_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kga_pkg::*;

	// command and status between sequencer and datapath
	kga_cmd_t  cmd;
	kga_stat_t stat;

	// sequencer: clear sweep, decode, search steps, scaling
	kga_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// tables, search bounds, arithmetic and result register
	kga_datapath #(
		.GLYPH_SLOTS  (GLYPH_SLOTS),
		.KERN_ENTRIES (KERN_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.char_code      (char_code),
		.prev_code      (prev_code),
		.glyph_advance  (glyph_advance),
		.glyph_offset   (glyph_offset),
		.glyph_has_kern (glyph_has_kern),
		.kern_slot      (kern_slot),
		.kern_amount    (kern_amount),
		.done           (done),
		.width          (width),
		.unknown_char   (unknown_char),
		.kern_applied   (kern_applied)
	);

endmodule

FILE: hw/rtl/kga_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kga_checker
// Port-level timing checks for the kerned glyph advance block.
// ----------------------------------------------------------------------------
module kga_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted beat moves the block out of idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after request beat");

	// no result in the cycle right after a request beat
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after request beat");

	// results come one per item, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	// a result is shown only once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

endmodule

bind kerned_glyph_advance kga_checker u_kga_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
